### rtl/ltu_pkg.sv
// Shared types, constants and calendar helpers for the local-to-UTC date/time shifter.
// Has no dependencies. The top level and the bench import it.
package ltu_pkg;

  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned TzW     = 8;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned TotalW  = 13;  // signed minute count of the day, -1905..3843
  localparam int unsigned TodW    = 11;  // minute of day after the day steps, 0..1439

  localparam logic signed [TotalW-1:0] MinPerDay     = 13'sd1440;
  localparam logic signed [TotalW-1:0] MinPerQuarter = 13'sd15;
  localparam logic [YearW-1:0]         YearMax       = 7'd127;
  localparam logic [MonthW-1:0]        MonthJan      = 4'd1;
  localparam logic [MonthW-1:0]        MonthFeb      = 4'd2;
  localparam logic [MonthW-1:0]        MonthDec      = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t                     date;
    logic signed [TotalW-1:0]  total;
    logic [SecondW-1:0]        second;
  } shift_t;

  typedef struct packed {
    date_t               date;
    logic [SecondW-1:0]  second;
    logic [TodW-1:0]     tod;
    logic [HourW-1:0]    hour_est;
    logic [7:0]          wsum;
  } split_t;

  typedef struct packed {
    date_t               date;
    logic [SecondW-1:0]  second;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [WdayW-1:0]    weekday;
  } result_t;

  // Days in a month; months outside 1..12 count 31 days.
  function automatic logic [DayW-1:0] days_of(logic [YearW-1:0] year,
                                              logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    case (month)
      4'd2:                      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Sakamoto month offset; 0 for months outside 1..12.
  function automatic logic [2:0] dow_offset(logic [MonthW-1:0] month);
    logic [2:0] off;
    case (month)
      4'd2, 4'd6:          off = 3'd3;
      4'd3, 4'd11:         off = 3'd2;
      4'd4:                off = 3'd5;
      4'd7:                off = 3'd5;
      4'd8:                off = 3'd1;
      4'd9, 4'd12:         off = 3'd4;
      4'd10:               off = 3'd6;
      default:             off = 3'd0;
    endcase
    return off;
  endfunction

  function automatic date_t step_back(date_t d);
    date_t n;
    n = d;
    if (d.day > 5'd1) begin
      n.day = d.day - 5'd1;
    end else begin
      if (d.month > MonthJan) begin
        n.month = d.month - 4'd1;
      end else begin
        n.month = MonthDec;
        if (d.year != '0) n.year = d.year - 7'd1;
      end
      n.day = days_of(n.year, n.month);
    end
    return n;
  endfunction

  function automatic date_t step_fwd(date_t d);
    date_t n;
    n = d;
    if (d.day < days_of(d.year, d.month)) begin
      n.day = d.day + 5'd1;
    end else begin
      n.day = 5'd1;
      if (d.month < MonthDec) begin
        n.month = d.month + 4'd1;
      end else begin
        n.month = MonthJan;
        if (d.year < YearMax) n.year = d.year + 7'd1;
      end
    end
    return n;
  endfunction

  // Move at most one day toward the range 0..1439 minutes.
  function automatic shift_t day_shift(shift_t s);
    shift_t n;
    n = s;
    if (s.total < 0) begin
      n.date  = step_back(s.date);
      n.total = s.total + MinPerDay;
    end else if (s.total >= MinPerDay) begin
      n.date  = step_fwd(s.date);
      n.total = s.total - MinPerDay;
    end
    return n;
  endfunction

endpackage

### rtl/ltu_if.sv
// Valid/ready channel interfaces for local time items in and UTC items out.
// No dependencies beyond the widths written here.
interface ltu_in_if;
  logic              valid;
  logic              ready;
  logic [6:0]        year_in;
  logic [3:0]        month_in;
  logic [4:0]        day_in;
  logic [4:0]        hour_in;
  logic [5:0]        minute_in;
  logic [5:0]        second_in;
  logic signed [7:0] tz_quarters;

  modport source (output valid, year_in, month_in, day_in, hour_in, minute_in,
                  second_in, tz_quarters, input ready);
  modport sink   (input valid, year_in, month_in, day_in, hour_in, minute_in,
                  second_in, tz_quarters, output ready);
endinterface

interface ltu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] year_out;
  logic [3:0] month_out;
  logic [4:0] day_out;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic [2:0] weekday;

  modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
                  second_out, weekday, input ready);
  modport sink   (input valid, year_out, month_out, day_out, hour_out, minute_out,
                  second_out, weekday, output ready);
endinterface

### rtl/local_to_utc_date_time_shift.sv
// Local-to-UTC calendar shift: five-stage pipeline, one item in and one out per cycle
// while the output channel is ready; an item is registered in stages 1 to 5 in turn.
// Throughput: 1 item per cycle; each stage holds one item and frees itself when the
// stage after it moves, so a stalled output fills the pipeline before input stops.
// Reset: rst_ni (async, active low) clears all stage valid bits; payloads are not reset.
// Depends on ltu_pkg and the ltu_in_if / ltu_out_if interfaces.
module local_to_utc_date_time_shift
  import ltu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ltu_in_if.sink     in_i,
  ltu_out_if.source  out_o
);

  // Stage valid bits and per-stage advance enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  shift_t  s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  split_t  s4_d, s4_q;
  result_t s5_d, s5_q;

  // A stage takes a new item when empty or when its own item moves on.
  assign en5 = !v5_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // Stage 1: minute of day minus the zone offset, as a signed count.
  logic [TotalW-1:0] hm;
  logic [TotalW-1:0] tz_x;
  always_comb begin
    hm   = ({8'd0, in_i.hour_in} * 13'd60) + {7'd0, in_i.minute_in};
    tz_x = {{(TotalW-TzW){in_i.tz_quarters[TzW-1]}}, in_i.tz_quarters};
    s1_d.date.year  = in_i.year_in;
    s1_d.date.month = in_i.month_in;
    s1_d.date.day   = in_i.day_in;
    s1_d.second     = in_i.second_in;
    s1_d.total      = $signed(hm) - ($signed(tz_x) * MinPerQuarter);
  end

  // Stages 2 and 3: at most two whole days are crossed in either direction,
  // so two single-day steps bring the count into 0..1439.
  assign s2_d = day_shift(s1_q);
  assign s3_d = day_shift(s2_q);

  // Stage 4: estimate the hour and build the weekday sum.
  // hour_est = floor(tod*17/1024) is the true hour or one below it.
  // The weekday sum folds Sakamoto's constants: 2000+500-20+5 is a multiple
  // of 7, and years from 2100 up lose one more for the century term.
  logic [TodW-1:0]   tod;
  logic [14:0]       hprod;
  logic              jan_feb;
  logic signed [8:0] yy, yq;
  logic [9:0]        ws;
  always_comb begin
    tod     = s3_q.total[TodW-1:0];
    hprod   = {4'd0, tod} * 15'd17;
    jan_feb = (s3_q.date.month == MonthJan) || (s3_q.date.month == MonthFeb);
    yy      = $signed({2'b00, s3_q.date.year}) - $signed({8'd0, jan_feb});
    yq      = yy >>> 2;
    ws      = 10'(yy) + 10'(yq) + {7'd0, dow_offset(s3_q.date.month)}
              + {5'd0, s3_q.date.day} + 10'd7 - {9'd0, (yy >= 9'sd100)};
    s4_d.date     = s3_q.date;
    s4_d.second   = s3_q.second;
    s4_d.tod      = tod;
    s4_d.hour_est = hprod[14:10];
    s4_d.wsum     = ws[7:0];
  end

  // Stage 5: correct the hour estimate and reduce the weekday sum mod 7
  // by folding octal digits (8 is 1 mod 7).
  logic [TodW-1:0] rem;
  logic [4:0]      f1;
  logic [3:0]      f2;
  logic [3:0]      wmod;
  always_comb begin
    rem = s4_q.tod - ({6'd0, s4_q.hour_est} * 11'd60);
    s5_d.date   = s4_q.date;
    s5_d.second = s4_q.second;
    if (rem >= 11'd60) begin
      s5_d.hour   = s4_q.hour_est + 5'd1;
      s5_d.minute = 6'(rem - 11'd60);
    end else begin
      s5_d.hour   = s4_q.hour_est;
      s5_d.minute = rem[MinuteW-1:0];
    end
    f1   = {3'd0, s4_q.wsum[7:6]} + {2'd0, s4_q.wsum[5:3]} + {2'd0, s4_q.wsum[2:0]};
    f2   = {2'd0, f1[4:3]} + {1'b0, f1[2:0]};
    wmod = (f2 >= 4'd7) ? (f2 - 4'd7) : f2;
    s5_d.weekday = wmod[2:0] + 3'd1;
  end

  // Valid bits: cleared by reset, advanced with their stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Payload: load on advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
    if (en5) s5_q <= s5_d;
  end

  assign out_o.valid      = v5_q;
  assign out_o.year_out   = s5_q.date.year;
  assign out_o.month_out  = s5_q.date.month;
  assign out_o.day_out    = s5_q.date.day;
  assign out_o.hour_out   = s5_q.hour;
  assign out_o.minute_out = s5_q.minute;
  assign out_o.second_out = s5_q.second;
  assign out_o.weekday    = s5_q.weekday;

  // An accepted item always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item did not enter stage 1");

  // Time of day leaving the pipeline is always normalized.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (s5_q.hour < 5'd24) && (s5_q.minute < 6'd60))
    else $error("result time of day out of range");

  // Weekday is 1..7.
  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (s5_q.weekday != 3'd0))
    else $error("result weekday out of range");

  // After the day steps the minute count is inside one day.
  a_day_steps_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (s3_q.total >= 0) && (s3_q.total < MinPerDay))
    else $error("minute count not normalized after two day steps");

endmodule

### bench/tb.sv
// Self-checking bench for the local-to-UTC calendar shifter: directed calendar corners,
// then random traffic with idling and backpressure on both channels.
// Depends on ltu_pkg, the ltu_in_if / ltu_out_if interfaces and the top level.
module tb
  import ltu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DayMinutes     = 1440;
  localparam int QuarterMinutes = 15;
  localparam int WeekDays       = 7;
  localparam int YearCeiling    = 127;
  localparam int PipeLatency    = 5;
  localparam int SettleCycles   = 4 * PipeLatency;
  localparam int CycleLimit     = 200000;
  localparam int ReportLimit    = 40;
  localparam int MaxIdle        = 15;
  localparam int LongHold       = 300;

  localparam int MonthLength[12]    = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int SakamotoOffset[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  typedef struct packed {
    logic [YearW-1:0]      year;
    logic [MonthW-1:0]     month;
    logic [DayW-1:0]       day;
    logic [HourW-1:0]      hour;
    logic [MinuteW-1:0]    minute;
    logic [SecondW-1:0]    second;
    logic signed [TzW-1:0] tz;
  } local_time_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [WdayW-1:0]   weekday;
  } utc_time_t;

  logic clk;
  logic rst_ni;

  ltu_in_if  in_ch ();
  ltu_out_if out_ch ();

  local_to_utc_date_time_shift dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // UTC results still owed by the block, oldest first.
  utc_time_t utc_expected[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  tx_idle        = 1'b1;
  bit  rx_idle        = 1'b1;
  int  rx_hold_cycles = 0;

  string field_name[7] = '{"year", "month", "day", "hour", "minute", "second", "weekday"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("local_to_utc_date_time_shift test failed");
      $finish;
    end
  end

  // Days in a month under the every-fourth-year leap rule; months outside 1..12 count 31.
  function automatic int month_days(int year, int month);
    if (month < 1 || month > 12) return 31;
    if (month == 2 && (year % 4) == 0) return 29;
    return MonthLength[month-1];
  endfunction

  // Shift a local time to UTC: subtract the zone offset from the minute of day,
  // then walk the date one day at a time until the minute count lands in a day.
  function automatic utc_time_t shift_to_utc(local_time_t lt);
    int total;
    int year;
    int month;
    int day;
    int tzq;
    int y;
    int off;
    utc_time_t u;
    tzq   = int'(lt.tz);
    year  = int'(lt.year);
    month = int'(lt.month);
    day   = int'(lt.day);
    total = int'(lt.hour) * 60 + int'(lt.minute) - tzq * QuarterMinutes;
    while (total < 0) begin
      total += DayMinutes;
      if (day > 1) begin
        day--;
      end else begin
        if (month > 1) begin
          month--;
        end else begin
          // Stepping back out of January; year zero holds.
          month = 12;
          if (year > 0) year--;
        end
        day = month_days(year, month);
      end
    end
    while (total >= DayMinutes) begin
      total -= DayMinutes;
      if (day < month_days(year, month)) begin
        day++;
      end else begin
        // Also covers a day already past the month length.
        day = 1;
        if (month < 12) begin
          month++;
        end else begin
          month = 1;
          if (year < YearCeiling) year++;
        end
      end
    end
    // Day of week: months outside 1..12 take offset 0 and no January/February shift.
    y   = 2000 + year;
    off = 0;
    if (month >= 1 && month <= 12) begin
      off = SakamotoOffset[month-1];
      if (month < 3) y--;
    end
    u.year    = YearW'(year);
    u.month   = MonthW'(month);
    u.day     = DayW'(day);
    u.hour    = HourW'(total / 60);
    u.minute  = MinuteW'(total % 60);
    u.second  = lt.second;
    u.weekday = WdayW'((y + y / 4 - y / 100 + y / 400 + off + day) % WeekDays + 1);
    return u;
  endfunction

  function automatic local_time_t make_local(int year, int month, int day, int hour,
                                             int minute, int second, int tz);
    local_time_t lt;
    lt.year   = YearW'(year);
    lt.month  = MonthW'(month);
    lt.day    = DayW'(day);
    lt.hour   = HourW'(hour);
    lt.minute = MinuteW'(minute);
    lt.second = SecondW'(second);
    lt.tz     = TzW'(tz);
    return lt;
  endfunction

  // Mostly well-formed times with day pushed toward month edges; the rest is
  // raw noise over the full field widths.
  function automatic local_time_t random_local();
    local_time_t lt;
    int          last;
    logic [63:0] noise;
    if ($urandom_range(0, 3) != 0) begin
      lt.year  = YearW'($urandom_range(0, 99));
      lt.month = MonthW'($urandom_range(1, 12));
      last     = month_days(int'(lt.year), int'(lt.month));
      case ($urandom_range(0, 2))
        0:       lt.day = 5'd1;
        1:       lt.day = DayW'(last);
        default: lt.day = DayW'($urandom_range(1, last));
      endcase
      lt.hour   = HourW'($urandom_range(0, 23));
      lt.minute = MinuteW'($urandom_range(0, 59));
      lt.second = SecondW'($urandom_range(0, 59));
      lt.tz     = TzW'(int'($urandom_range(0, 198)) - 99);
    end else begin
      noise = {$urandom, $urandom};
      lt    = noise[$bits(local_time_t)-1:0];
    end
    return lt;
  endfunction

  // Offer one item, after a random gap if tx_idle is set; hold it until accepted.
  // Valid stays high on return so a back-to-back item follows without a bubble.
  task automatic send_local(input local_time_t lt);
    int gap;
    gap = tx_idle ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.year_in     <= lt.year;
    in_ch.month_in    <= lt.month;
    in_ch.day_in      <= lt.day;
    in_ch.hour_in     <= lt.hour;
    in_ch.minute_in   <= lt.minute;
    in_ch.second_in   <= lt.second;
    in_ch.tz_quarters <= lt.tz;
    do @(posedge clk); while (!in_ch.ready);
    utc_expected.push_back(shift_to_utc(lt));
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (utc_expected.size() != 0);
  endtask

  task automatic test_calendar_corners();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // Back out of January 1 of year zero, once and twice.
    send_local(make_local(0, 1, 1, 0, 0, 0, 4));
    send_local(make_local(0, 1, 1, 0, 0, 59, 127));
    // Forward out of December 31: saturate at the top year, reach year 100.
    send_local(make_local(127, 12, 31, 23, 59, 0, -4));
    send_local(make_local(99, 12, 31, 23, 0, 30, -8));
    // Largest minute count: hour and minute at full width, most negative offset.
    send_local(make_local(127, 15, 31, 31, 63, 63, -128));
    // Leap handling around February.
    send_local(make_local(4, 2, 28, 23, 0, 0, -8));
    send_local(make_local(5, 2, 28, 23, 0, 0, -8));
    send_local(make_local(0, 3, 1, 1, 0, 0, 8));
    // Day past month length forward and back, day zero with and without a step.
    send_local(make_local(1, 2, 31, 20, 0, 0, -20));
    send_local(make_local(1, 4, 31, 1, 0, 0, 8));
    send_local(make_local(1, 3, 0, 1, 0, 0, 8));
    send_local(make_local(1, 6, 0, 12, 0, 0, 0));
    // Month out of range: zero back and forward, 13 back, 14 untouched, 15 at the top.
    send_local(make_local(3, 0, 1, 2, 0, 0, 16));
    send_local(make_local(3, 0, 31, 22, 0, 0, -16));
    send_local(make_local(3, 13, 1, 0, 30, 0, 4));
    send_local(make_local(3, 14, 10, 12, 0, 0, 0));
    // Zero offset, hour out of range, extreme offsets, all-zero item.
    send_local(make_local(50, 7, 15, 12, 34, 56, 0));
    send_local(make_local(20, 6, 15, 31, 63, 0, 0));
    send_local(make_local(20, 2, 29, 0, 0, 0, -128));
    send_local(make_local(127, 1, 1, 0, 0, 0, 0));
    send_local(make_local(0, 0, 0, 0, 0, 0, 0));
    send_local(make_local(10, 10, 31, 0, 0, 0, -99));
    send_local(make_local(8, 12, 31, 23, 59, 59, 99));
    send_local(make_local(0, 0, 0, 0, 0, 0, 127));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input bit idle_in, input bit idle_out);
    tx_idle = idle_in;
    rx_idle = idle_out;
    repeat (count) send_local(random_local());
  endtask

  // Stall the output long enough that the pipeline fills and input backs up,
  // while the sender keeps offering at full rate.
  task automatic test_output_backpressure();
    drain_results();
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    rx_hold_cycles = LongHold;
    repeat (80) send_local(random_local());
  endtask

  // Burst, let the block empty completely, burst again.
  task automatic test_pause_for_drain();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    repeat (30) send_local(random_local());
    drain_results();
    repeat (30) send_local(random_local());
  endtask

  // Receiver: random stall before each item when rx_idle is set, plus one long hold when asked.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_ni !== 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, MaxIdle) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare every accepted result, field by field, with the oldest expectation.
  always @(posedge clk) begin
    utc_time_t exp_u;
    int        exp_f[7];
    int        got_f[7];
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (utc_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("%0t: result with no item outstanding: %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                   $time, out_ch.year_out, out_ch.month_out, out_ch.day_out,
                   out_ch.hour_out, out_ch.minute_out, out_ch.second_out, out_ch.weekday);
      end else begin
        exp_u = utc_expected.pop_front();
        exp_f = '{int'(exp_u.year), int'(exp_u.month), int'(exp_u.day), int'(exp_u.hour),
                  int'(exp_u.minute), int'(exp_u.second), int'(exp_u.weekday)};
        got_f = '{int'(out_ch.year_out), int'(out_ch.month_out), int'(out_ch.day_out),
                  int'(out_ch.hour_out), int'(out_ch.minute_out), int'(out_ch.second_out),
                  int'(out_ch.weekday)};
        for (int i = 0; i < 7; i++) begin
          if (exp_f[i] !== got_f[i]) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display("%0t: %s expected %0d, got %0d", $time, field_name[i],
                       exp_f[i], got_f[i]);
          end
        end
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.year_in       <= '0;
    in_ch.month_in      <= '0;
    in_ch.day_in        <= '0;
    in_ch.hour_in       <= '0;
    in_ch.minute_in     <= '0;
    in_ch.second_in     <= '0;
    in_ch.tz_quarters   <= '0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_calendar_corners();
    test_random_traffic(400, 1'b1, 1'b1);
    test_random_traffic(200, 1'b0, 1'b0);
    test_output_backpressure();
    test_random_traffic(150, 1'b1, 1'b0);
    test_random_traffic(150, 1'b0, 1'b1);
    test_pause_for_drain();
    test_random_traffic(100, 1'b1, 1'b1);

    // Empty the pipeline, then give a stray extra result time to show up.
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && utc_expected.size() == 0) begin
      $display("local_to_utc_date_time_shift test passed");
    end else begin
      $display("local_to_utc_date_time_shift test failed");
    end
    $finish;
  end

endmodule
